// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the frame receiver RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bfrf_pkg.sv =====
// ---------------------------------------------------------------------------
// bfrf_pkg
// Types and constants of the binary frame receiver with Fletcher checksum.
// ---------------------------------------------------------------------------
package bfrf_pkg;

   localparam logic [7:0]  SyncFirst  = 8'hB5;
   localparam logic [7:0]  SyncSecond = 8'h62;
   localparam logic [15:0] MaxPayload = 16'd512;

   typedef enum logic [8:0] {
      PH_HUNT1   = 9'b000000001,
      PH_HUNT2   = 9'b000000010,
      PH_CLASS   = 9'b000000100,
      PH_ID      = 9'b000001000,
      PH_LEN_LO  = 9'b000010000,
      PH_LEN_HI  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CK_A    = 9'b010000000,
      PH_CK_B    = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_BADSUM  = 2'd2,
      KIND_TOOLONG = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    out_kind;
      logic [7:0]  out_byte;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_length;
      logic        frame_last;
   } result_type;

endpackage

// ===== rtl/bfrf_in_reg.sv =====
// ---------------------------------------------------------------------------
// bfrf_in_reg
// Input register holding one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module bfrf_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_tdata;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ===== rtl/bfrf_parse.sv =====
// ---------------------------------------------------------------------------
// bfrf_parse
// Frame parser: phase sequencer, header capture and running Fletcher sum.
// ---------------------------------------------------------------------------
module bfrf_parse import bfrf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic        ck_ok_ff, ck_ok_in;

   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [15:0] len_full;
   logic [15:0] count_inc;

   assign add_a     = sum_a_ff + rx_byte;
   assign add_b     = sum_b_ff + add_a;
   assign len_full  = {rx_byte, len_ff[7:0]};
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      ck_ok_in  = ck_ok_ff;
      res_valid = 1'b0;
      res.out_kind       = KIND_PAYLOAD;
      res.out_byte       = 8'd0;
      res.msg_class      = class_ff;
      res.msg_id         = id_ff;
      res.payload_length = len_ff;
      res.frame_last     = 1'b0;
      case (phase_ff)
         PH_HUNT2: begin
            if (rx_byte == SyncSecond) begin
               phase_in = PH_CLASS;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else if (rx_byte != SyncFirst) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in   = {8'd0, rx_byte};
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = len_full;
            sum_a_in = add_a;
            sum_b_in = add_b;
            count_in = 16'd0;
            res.payload_length = len_full;
            if (len_full > MaxPayload) begin
               phase_in       = PH_HUNT1;
               res_valid      = 1'b1;
               res.out_kind   = KIND_TOOLONG;
               res.frame_last = 1'b1;
            end else if (len_full == 16'd0) begin
               phase_in = PH_CK_A;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in = add_a;
            sum_b_in = add_b;
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               phase_in = PH_CK_A;
            end
            res_valid    = 1'b1;
            res.out_byte = rx_byte;
         end
         PH_CK_A: begin
            ck_ok_in = (rx_byte == sum_a_ff);
            phase_in = PH_CK_B;
         end
         PH_CK_B: begin
            phase_in       = PH_HUNT1;
            res_valid      = 1'b1;
            res.frame_last = 1'b1;
            if (ck_ok_ff && (rx_byte == sum_b_ff)) begin
               res.out_kind = KIND_ACCEPT;
            end else begin
               res.out_kind = KIND_BADSUM;
            end
         end
         default: begin
            phase_in = (rx_byte == SyncFirst) ? PH_HUNT2 : PH_HUNT1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         class_ff <= 8'd0;
         id_ff    <= 8'd0;
         len_ff   <= 16'd0;
         count_ff <= 16'd0;
         sum_a_ff <= 8'd0;
         sum_b_ff <= 8'd0;
         ck_ok_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         ck_ok_ff <= ck_ok_in;
      end
   end

endmodule

// ===== rtl/bfrf_out_reg.sv =====
// ---------------------------------------------------------------------------
// bfrf_out_reg
// Result register holding one result transaction until it is taken.
// ---------------------------------------------------------------------------
module bfrf_out_reg import bfrf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic       res_valid,
   input  result_type res,
   output logic       advance,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;
   result_type res_in;
   logic       room;

   assign room    = !valid_ff || out_ready;
   assign advance = byte_valid && room;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      res_in   = res_ff;
      if (advance && res_valid) begin
         valid_in = 1'b1;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

// ===== rtl/binary_frame_receiver_fletcher.sv =====
// ---------------------------------------------------------------------------
// binary_frame_receiver_fletcher
// Receives bytes, finds sync-framed messages, streams their payload and
// reports each frame end after checking the 8-bit Fletcher checksum, or a too-long length.
// ---------------------------------------------------------------------------
//   Channel  Direction  Carries
//   req_     in         one received byte per transaction
//   rsp_     out        payload byte or frame status per transaction
//
// One byte is accepted every cycle while no result is stalled.
// The parser state updates once per byte, between the input and result registers.
// Reset returns the parser to hunting the first sync byte and empties both registers.
// A stalled result stops the parser; the input register still takes one byte.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_frame_receiver_fletcher import bfrf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [15:8] msg_class,
                                    // [23:16] msg_id, [39:24] payload_length
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast    // frame_last
);

   logic       advance;
   logic       byte_valid;
   logic [7:0] byte_data;
   logic       res_valid;
   result_type res;
   result_type out_res;

   bfrf_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   bfrf_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rx_byte   (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   bfrf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .res_valid  (res_valid),
      .res        (res),
      .advance    (advance),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_res    (out_res)
   );

   assign rsp_tdata = {out_res.payload_length, out_res.msg_id,
                       out_res.msg_class, out_res.out_byte};
   assign rsp_tuser = out_res.out_kind;
   assign rsp_tlast = out_res.frame_last;

   `ASSERT_CLK(a_last_is_status, clock, reset,
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_PAYLOAD)),
      "status transaction and frame end disagree")
   `ASSERT_CLK(a_status_byte_zero, clock, reset,
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[7:0] == 8'd0),
      "status transaction carries a non-zero byte")
   `ASSERT_CLK(a_full_stall_blocks, clock, reset,
      (byte_valid && rsp_tvalid && !rsp_tready) |-> !req_tready,
      "byte accepted while both registers are held")
   `ASSERT_CLK_ALWAYS(a_empty_after_reset, clock,
      $past(reset) |-> (!rsp_tvalid && !byte_valid),
      "registers not empty after reset")

endmodule

// ===== dv/frame_result_check.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_result_check
// Watches both channels of the frame receiver, parses every accepted byte
// with its own frame parser and compares each result transaction, field by
// field, with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module frame_result_check import bfrf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [7:0] out_byte, [15:8] msg_class,
                                    // [23:16] msg_id, [39:24] payload_length
   input  logic [1:0]  rsp_tuser,   // [1:0] out_kind
   input  logic        rsp_tlast,   // frame_last
   output int          mismatches,
   output int          outstanding
);

   phase_type   rx_phase;
   logic [7:0]  frame_class;
   logic [7:0]  frame_id;
   logic [15:0] frame_len;
   logic [15:0] bytes_taken;
   logic [7:0]  run_a;
   logic [7:0]  run_b;
   logic        ck_a_ok;
   result_type  awaited_outputs[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic void fletcher_add(input logic [7:0] b);
      run_a = run_a + b;
      run_b = run_b + run_a;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] b);
      result_type r;
      logic       produces;
      r        = '0;
      produces = 1'b0;
      case (rx_phase)
         PH_HUNT2: begin
            if (b == SyncSecond) begin
               rx_phase = PH_CLASS;
               run_a    = 8'h00;
               run_b    = 8'h00;
            end else if (b != SyncFirst) begin
               rx_phase = PH_HUNT1;
            end
         end
         PH_CLASS: begin
            frame_class = b;
            fletcher_add(b);
            rx_phase = PH_ID;
         end
         PH_ID: begin
            frame_id = b;
            fletcher_add(b);
            rx_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_len = {8'h00, b};
            fletcher_add(b);
            rx_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_len[15:8] = b;
            fletcher_add(b);
            bytes_taken = 16'd0;
            if (frame_len > MaxPayload) begin
               rx_phase     = PH_HUNT1;
               produces     = 1'b1;
               r.out_kind   = KIND_TOOLONG;
               r.frame_last = 1'b1;
            end else begin
               rx_phase = (frame_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            fletcher_add(b);
            bytes_taken = bytes_taken + 16'd1;
            if (bytes_taken >= frame_len) rx_phase = PH_CK_A;
            produces   = 1'b1;
            r.out_kind = KIND_PAYLOAD;
            r.out_byte = b;
         end
         PH_CK_A: begin
            ck_a_ok  = (b == run_a);
            rx_phase = PH_CK_B;
         end
         PH_CK_B: begin
            rx_phase     = PH_HUNT1;
            produces     = 1'b1;
            r.out_kind   = (ck_a_ok && b == run_b) ? KIND_ACCEPT : KIND_BADSUM;
            r.frame_last = 1'b1;
         end
         default: begin
            rx_phase = (b == SyncFirst) ? PH_HUNT2 : PH_HUNT1;
         end
      endcase
      if (produces) begin
         r.msg_class      = frame_class;
         r.msg_id         = frame_id;
         r.payload_length = frame_len;
         awaited_outputs.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      logic       bad;
      bad = 1'b0;
      if (reset) begin
         rx_phase    = PH_HUNT1;
         frame_class = 8'h00;
         frame_id    = 8'h00;
         frame_len   = 16'd0;
         bytes_taken = 16'd0;
         run_a       = 8'h00;
         run_b       = 8'h00;
         ck_a_ok     = 1'b0;
         awaited_outputs.delete();
      end else begin
         // Results are retired before the byte of this cycle is parsed, since
         // a byte never produces its result in the cycle it is taken.
         if (rsp_tvalid && rsp_tready) begin
            seen.out_kind       = kind_type'(rsp_tuser);
            seen.out_byte       = rsp_tdata[7:0];
            seen.msg_class      = rsp_tdata[15:8];
            seen.msg_id         = rsp_tdata[23:16];
            seen.payload_length = rsp_tdata[39:24];
            seen.frame_last     = rsp_tlast;
            if (awaited_outputs.size() == 0) begin
               bad = 1'b1;
               $display("%0t: unexpected result, kind %0d byte %h class %h id %h len %0d last %b",
                        $time, seen.out_kind, seen.out_byte, seen.msg_class, seen.msg_id,
                        seen.payload_length, seen.frame_last);
            end else begin
               want = awaited_outputs.pop_front();
               if (seen.out_kind !== want.out_kind) begin
                  bad = 1'b1;
                  $display("%0t: out_kind expected %0d, actual %0d",
                           $time, want.out_kind, seen.out_kind);
               end
               if (seen.out_byte !== want.out_byte) begin
                  bad = 1'b1;
                  $display("%0t: out_byte expected %h, actual %h",
                           $time, want.out_byte, seen.out_byte);
               end
               if (seen.msg_class !== want.msg_class) begin
                  bad = 1'b1;
                  $display("%0t: msg_class expected %h, actual %h",
                           $time, want.msg_class, seen.msg_class);
               end
               if (seen.msg_id !== want.msg_id) begin
                  bad = 1'b1;
                  $display("%0t: msg_id expected %h, actual %h",
                           $time, want.msg_id, seen.msg_id);
               end
               if (seen.payload_length !== want.payload_length) begin
                  bad = 1'b1;
                  $display("%0t: payload_length expected %0d, actual %0d",
                           $time, want.payload_length, seen.payload_length);
               end
               if (seen.frame_last !== want.frame_last) begin
                  bad = 1'b1;
                  $display("%0t: frame_last expected %b, actual %b",
                           $time, want.frame_last, seen.frame_last);
               end
            end
         end
         if (req_tvalid && req_tready) parse_rx_byte(req_tdata);
      end
      if (bad) mismatches <= mismatches + 1;
      outstanding <= awaited_outputs.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Feeds the frame receiver with a byte stream of directed frames followed by
// random well-formed, corrupted, oversized and broken frames mixed with line
// noise, with random idling on both channels, and reports the verdict.
// ---------------------------------------------------------------------------
module testbench import bfrf_pkg::*; ();

   typedef enum {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_fault_type;

   localparam int IdleLimit = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [7:0] out_byte, [15:8] msg_class,
                             // [23:16] msg_id, [39:24] payload_length
   logic [1:0]  rsp_tuser;   // [1:0] out_kind
   logic        rsp_tlast;   // frame_last

   int mismatches;
   int outstanding;
   int idle_cycles;
   int ready_left;
   int parsed_bytes;
   int frame_count;
   bit steady_sender;

   binary_frame_receiver_fletcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   frame_result_check result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left <= ready_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         ready_left <= idle_span();
      end else begin
         rsp_tready <= 1'b1;
         ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 40);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady_sender ? 0 : idle_span();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Oversized lengths stop after the header; the checksum bytes are computed
   // here so that corruption can be applied to either one on purpose.
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input ck_fault_type fault,
                             input bit extremes);
      logic [31:0] header;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic [7:0]  b;
      int          i;
      header        = {len[15:8], len[7:0], id, cls};
      sum_a         = 8'h00;
      sum_b         = 8'h00;
      steady_sender = ($urandom_range(0, 3) == 0);
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      for (i = 0; i < 4; i++) begin
         b     = header[8*i +: 8];
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
         send_byte(b);
      end
      parsed_bytes += 6;
      if (len > MaxPayload) return;
      for (i = 0; i < len; i++) begin
         b     = extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
         send_byte(b);
      end
      parsed_bytes += len + 2;
      send_byte((fault == CK_BAD_A) ? sum_a ^ 8'($urandom_range(1, 255)) : sum_a);
      send_byte((fault == CK_BAD_B) ? sum_b ^ 8'($urandom_range(1, 255)) : sum_b);
   endtask

   initial begin
      int          pick;
      int          r;
      logic [15:0] len;
      ck_fault_type fault;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      rsp_tready   = 1'b0;
      idle_cycles  = 0;
      ready_left   = 0;
      parsed_bytes = 0;
      frame_count  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Repeated first sync byte, then an empty frame with extreme header bytes.
      steady_sender = 1'b0;
      send_byte(SyncFirst);
      send_frame(8'h00, 8'hFF, 16'd0, CK_GOOD, 1'b0);
      // Second sync byte missing.
      send_byte(SyncFirst);
      send_byte(8'h00);
      // Largest length field, far beyond the limit.
      send_frame(8'hFF, 8'h00, 16'hFFFF, CK_GOOD, 1'b0);
      // Payload of extreme bytes with a corrupted second checksum byte.
      send_frame(8'h12, 8'h34, 16'd2, CK_BAD_B, 1'b1);

      while (parsed_bytes < 500) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            steady_sender = 1'b0;
            send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 12) begin
            // Broken sequence: a lone first sync byte followed by anything.
            steady_sender = 1'b0;
            send_byte(SyncFirst);
            send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 17) begin
            len = ($urandom_range(0, 2) == 0) ? MaxPayload + 16'd1
                                              : 16'($urandom_range(513, 65535));
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       CK_GOOD, 1'b0);
         end else begin
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
                                              : 16'($urandom_range(0, 6));
            r = $urandom_range(0, 99);
            fault = (r < 70) ? CK_GOOD : (r < 85) ? CK_BAD_A : CK_BAD_B;
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       fault, 1'b0);
         end
         frame_count++;
         if (frame_count % 40 == 20) hold_until_drained();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
